// ===== hdl/cise_pkg.sv =====
// Shared types, constants and helper functions for the CAN id self-enumeration unit.
package cise_pkg;

  localparam int MAP_BYTES_DEF = 16;

  localparam int ID_W   = 7;
  localparam int TICK_W = 16;
  localparam int LEN_W  = 4;
  localparam int CFG_W  = 16;
  localparam int CFG_IDX_W = 2;

  localparam logic [ID_W-1:0]   ID_MAX         = 7'd99;
  localparam logic [ID_W-1:0]   ID_DEFAULT     = 7'd1;
  localparam logic [7:0]        FULL_BYTE      = 8'hFF;
  localparam logic [7:0]        ID0_BYTE       = 8'h01;
  localparam logic [TICK_W-1:0] TICK_MAX       = 16'hFFFF;
  localparam logic [TICK_W-1:0] HOLDOFF_RESET  = 16'd200;
  localparam logic [TICK_W-1:0] COLLECT_RESET  = 16'd100;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_START_ID = 2'd0,
    REG_HOLDOFF  = 2'd1,
    REG_COLLECT  = 2'd2
  } cfg_reg_t;

  typedef enum logic {
    CMD_TICK  = 1'b0,
    CMD_FRAME = 1'b1
  } cmd_t;

  typedef struct packed {
    logic            command;
    logic [ID_W-1:0] sender_id;
    logic            remote_request;
    logic [LEN_W-1:0] payload_length;
  } in_item_t;

  typedef struct packed {
    logic            deliver_frame;
    logic            send_reply;
    logic            send_request;
    logic [ID_W-1:0] node_id;
    logic            id_changed;
    logic            enum_failed;
  } out_item_t;

  // Map an arbitrary value onto a usable node id.
  function automatic logic [ID_W-1:0] legal_id(input logic [ID_W-1:0] v);
    logic [ID_W-1:0] r;
    r = (v inside {[ID_DEFAULT:ID_MAX]}) ? v : ID_DEFAULT;
    return r;
  endfunction

  // Index of the lowest clear bit; only meaningful when the byte is not full.
  function automatic logic [2:0] first_zero(input logic [7:0] b);
    logic [2:0] r;
    r = 3'd0;
    for (int i = 7; i >= 0; i--) begin
      if (!b[i]) r = 3'(i);
    end
    return r;
  endfunction

endpackage

// ===== hdl/can_id_self_enumeration_unit.sv =====
// Top level of the CAN node id self-enumeration unit: sequencer, timer and used-id map.
// Flow: an accepted item passes through EVAL, FRAME and FINISH, where its result is
//   registered; a frame marked into the map also passes MARK_RD and MARK_WR, an
//   enumeration start first sweeps the whole map clear, and a free-id scan reads and
//   checks one map byte at a time (one map read port). Items are taken one at a time;
//   the next is taken only after the result leaves FINISH, which waits on a stalled result.
// Reset (rst, synchronous): control state, timer, configuration and node id return to their defaults;
//   the used-id map is left as is and is fully rewritten when an enumeration starts.
module can_id_self_enumeration_unit #(
  parameter int MAP_BYTES = cise_pkg::MAP_BYTES_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  cise_pkg::in_item_t            in_data,
  output logic                          out_valid,
  input  logic                          out_stall,
  output cise_pkg::out_item_t           out_data,
  input  logic                          cfg_wen,
  input  logic [cise_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [cise_pkg::CFG_W-1:0]    cfg_data
);
  import cise_pkg::*;

  localparam int ADDR_W = (MAP_BYTES > 1) ? $clog2(MAP_BYTES) : 1;
  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(MAP_BYTES - 1);

  // One-hot sequencer states.
  typedef enum logic [8:0] {
    ST_IDLE     = 9'b000000001,
    ST_EVAL     = 9'b000000010,
    ST_CLEAR    = 9'b000000100,
    ST_SCAN_RD  = 9'b000001000,
    ST_SCAN_CHK = 9'b000010000,
    ST_FRAME    = 9'b000100000,
    ST_MARK_RD  = 9'b001000000,
    ST_MARK_WR  = 9'b010000000,
    ST_FINISH   = 9'b100000000
  } state_t;

  state_t state;

  // Configuration and persistent state.
  logic [TICK_W-1:0] holdoff_ticks;
  logic [TICK_W-1:0] collect_ticks;
  logic [ID_W-1:0]   current_id;
  logic              enum_pending;
  logic              enum_active;
  logic [TICK_W-1:0] elapsed_ticks;

  // Item held while the sequencer works on it.
  in_item_t item;
  logic deliver, reply, request, changed, failed;

  // Map sweep / scan address.
  logic [ADDR_W-1:0] addr;

  // Used-id map, one write port and one registered read port.
  logic [7:0] used_map [MAP_BYTES];
  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic [ADDR_W-1:0] mem_raddr;
  logic [7:0]        mem_wdata;
  logic [7:0]        rd_data;

  // Sender id split into map byte and bit.
  logic [ADDR_W-1:0] sender_addr;
  logic              sender_in_map;
  assign sender_addr   = ADDR_W'(item.sender_id[6:3]);
  assign sender_in_map = {1'b0, item.sender_id[6:3]} < 5'(MAP_BYTES);

  // A frame outside any enumeration phase that carries our own id.
  logic own_id_hit;
  assign own_id_hit = !enum_active && !enum_pending && item.sender_id == current_id;

  // Shared timer compare: the active phase picks its limit.
  logic [TICK_W-1:0] limit;
  logic              limit_passed;
  assign limit        = enum_pending ? holdoff_ticks : collect_ticks;
  assign limit_passed = elapsed_ticks > limit;

  // Candidate id from the byte just read during the scan.
  logic [ID_W-1:0] scan_id;
  assign scan_id = ID_W'({addr, first_zero(rd_data)});

  logic in_xfer, out_free;
  assign in_stall = (state != ST_IDLE);
  assign in_xfer  = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = addr;
    mem_wdata = 8'h00;
    mem_raddr = addr;
    case (state)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_wdata = (addr == '0) ? ID0_BYTE : 8'h00;
      end
      ST_MARK_RD: begin
        mem_raddr = sender_addr;
      end
      ST_MARK_WR: begin
        mem_we    = 1'b1;
        mem_waddr = sender_addr;
        mem_wdata = rd_data | (8'h01 << item.sender_id[2:0]);
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) used_map[mem_waddr] <= mem_wdata;
    rd_data <= used_map[mem_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      holdoff_ticks <= HOLDOFF_RESET;
      collect_ticks <= COLLECT_RESET;
      current_id    <= ID_DEFAULT;
      enum_pending  <= 1'b0;
      enum_active   <= 1'b0;
      elapsed_ticks <= '0;
      out_valid     <= 1'b0;
      addr          <= '0;
    end else begin
      // Drop a result once the consumer takes it, unless a new one replaces it.
      if (out_valid && !out_stall && state != ST_FINISH) out_valid <= 1'b0;

      case (state)
        ST_IDLE: begin
          if (in_xfer) begin
            item    <= in_data;
            deliver <= 1'b0;
            reply   <= 1'b0;
            request <= 1'b0;
            changed <= 1'b0;
            failed  <= 1'b0;
            // Advance the saturating tick count.
            if (in_data.command == CMD_TICK && elapsed_ticks != TICK_MAX)
              elapsed_ticks <= elapsed_ticks + 1'b1;
            state <= ST_EVAL;
          end
        end
        ST_EVAL: begin
          addr <= '0;
          if (enum_pending && limit_passed) begin
            // Hold-off over: start collecting with a fresh map.
            enum_active   <= 1'b1;
            enum_pending  <= 1'b0;
            elapsed_ticks <= '0;
            request       <= 1'b1;
            state         <= ST_CLEAR;
          end else if (enum_active && limit_passed) begin
            state <= ST_SCAN_RD;
          end else begin
            state <= ST_FRAME;
          end
        end
        ST_CLEAR: begin
          if (addr == LAST_ADDR) begin
            state <= ST_FRAME;
          end else begin
            addr <= addr + 1'b1;
          end
        end
        ST_SCAN_RD: begin
          state <= ST_SCAN_CHK;
        end
        ST_SCAN_CHK: begin
          if (rd_data != FULL_BYTE || addr == LAST_ADDR) begin
            if (rd_data != FULL_BYTE && scan_id >= ID_DEFAULT && scan_id <= ID_MAX) begin
              current_id <= scan_id;
              changed    <= 1'b1;
            end else begin
              failed <= 1'b1;
            end
            enum_active  <= 1'b0;
            enum_pending <= 1'b0;
            state        <= ST_FRAME;
          end else begin
            addr  <= addr + 1'b1;
            state <= ST_SCAN_RD;
          end
        end
        ST_FRAME: begin
          // Mark the sender while collecting, else go straight to the result.
          if (item.command == CMD_FRAME && enum_active && sender_in_map) begin
            state <= ST_MARK_RD;
          end else begin
            state <= ST_FINISH;
          end
          if (item.command == CMD_FRAME) begin
            // Another node holds our id: start the hold-off.
            if (own_id_hit) enum_pending <= 1'b1;
            // A conflict or a remote request restarts the timer.
            if (own_id_hit || item.remote_request) elapsed_ticks <= '0;
            if (item.remote_request) begin
              reply <= 1'b1;
            end else begin
              deliver <= (item.payload_length != '0);
            end
          end
        end
        ST_MARK_RD: begin
          state <= ST_MARK_WR;
        end
        ST_MARK_WR: begin
          state <= ST_FINISH;
        end
        ST_FINISH: begin
          // Hold the result until the output register is free.
          if (out_free) begin
            out_valid              <= 1'b1;
            out_data.deliver_frame <= deliver;
            out_data.send_reply    <= reply;
            out_data.send_request  <= request;
            out_data.node_id       <= current_id;
            out_data.id_changed    <= changed;
            out_data.enum_failed   <= failed;
            state                  <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase

      // Configuration writes must arrive only while the block is idle; the block itself does not enforce this.
      if (cfg_wen) begin
        case (cfg_index)
          REG_START_ID: current_id    <= legal_id(cfg_data[ID_W-1:0]);
          REG_HOLDOFF:  holdoff_ticks <= cfg_data;
          REG_COLLECT:  collect_ticks <= cfg_data;
          default:      ;
        endcase
      end
    end
  end

`ifndef ASSERT_OFF
  a_phase_exclusive: assert property (@(posedge clk) disable iff (rst)
    !(enum_pending && enum_active))
    else $error("pending and active phases overlap");

  a_result_from_finish: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == ST_FINISH))
    else $error("result raised outside the finish step");

  a_transfer_to_eval: assert property (@(posedge clk) disable iff (rst)
    in_xfer |=> state == ST_EVAL)
    else $error("accepted item did not enter evaluation");

  a_result_sane: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(out_data.id_changed && out_data.enum_failed)
                  && out_data.node_id >= ID_DEFAULT && out_data.node_id <= ID_MAX)
    else $error("inconsistent result flags or node id");
`endif

endmodule
